### design/assert_macros.svh
// Assertion macros used by the checker file icfm_chk.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ICFM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ICFM_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`endif

### design/icfm_pkg.sv
// Shared constants and controller/datapath interface types for the frequency meter.
// No dependencies; used by icfm_ctrl, icfm_dp and the top level.
package icfm_pkg;

	localparam int COUNTER_WIDTH_DEF = 16;
	localparam int CAP_W             = 16;
	localparam int FREQ_W            = 32;
	localparam int DIV_STEPS         = FREQ_W;
	localparam int STEP_W            = $clog2(DIV_STEPS);
	localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = 32'd48000000;

	typedef struct packed {
		logic load_first;
		logic start_div;
		logic step_div;
		logic set_result;
	} icfm_cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_busy;
	} icfm_sts_t;

endpackage

### design/input_capture_frequency_meter_top.sv
// Input-capture frequency meter, top level.
// Channels: capture request in (in_valid/in_ready/capture_value), result request out
// (out_valid/out_ready/period_ticks/frequency_hz/zero_period), one config register clock_hz.
// Captures are paired: the first of a pair is stored and yields no result, the second
// yields period_ticks, frequency_hz = clock_hz / period and zero_period.
// Sequence: a first capture is only stored. A second capture runs a restoring divider that
// retires one quotient bit per cycle, then loads the result register, which raises
// out_valid. in_ready stays low from a second capture until the result register is
// loaded, so no new capture is accepted while a division is in progress.
// in_ready is high whenever the divider is idle, even while a result waits in the
// output register. If the receiver stalls with a result still held when the next
// division finishes, the block holds that quotient and keeps in_ready low until the
// output register frees up.
// Reset (arst_n low): clears pairing state, stored first capture and the output valid;
// clock_hz returns to 48000000. cfg_wr_en writes clock_hz at once; write it only while idle.
// Depends on icfm_pkg, icfm_ctrl and icfm_dp.
module input_capture_frequency_meter_top #(
	parameter int COUNTER_WIDTH = icfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [icfm_pkg::FREQ_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [icfm_pkg::CAP_W-1:0]   capture_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [icfm_pkg::CAP_W-1:0]   period_ticks,
	output logic [icfm_pkg::FREQ_W-1:0]  frequency_hz,
	output logic                         zero_period
);

	icfm_pkg::icfm_cmd_t cmd;
	icfm_pkg::icfm_sts_t sts;

	icfm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	icfm_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.capture_value (capture_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.period_ticks  (period_ticks),
		.frequency_hz  (frequency_hz),
		.zero_period   (zero_period)
	);

endmodule

### design/icfm_ctrl.sv
// Controller for the frequency meter: capture pairing and divide sequencing.
// Depends on icfm_pkg.
module icfm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  icfm_pkg::icfm_sts_t sts,
	output icfm_pkg::icfm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   pending_q, pending_d;
	logic   in_req;

	assign in_ready = (state_q == ST_IDLE);
	assign in_req   = in_valid & in_ready;

	always_comb begin
		state_d   = state_q;
		pending_d = pending_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_req) begin
					if (!pending_q) begin
						cmd.load_first = 1'b1;
						pending_d      = 1'b1;
					end else begin
						cmd.start_div = 1'b1;
						pending_d     = 1'b0;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.step_div = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.set_result = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pending_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pending_q <= pending_d;
		end
	end

endmodule

### design/icfm_dp.sv
// Datapath for the frequency meter: first capture, period, restoring divider, result register.
// Depends on icfm_pkg.
module icfm_dp #(
	parameter int COUNTER_WIDTH = icfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [icfm_pkg::FREQ_W-1:0]       cfg_wr_data,
	input  logic [icfm_pkg::CAP_W-1:0]        capture_value,
	input  icfm_pkg::icfm_cmd_t               cmd,
	output icfm_pkg::icfm_sts_t               sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [icfm_pkg::CAP_W-1:0]        period_ticks,
	output logic [icfm_pkg::FREQ_W-1:0]       frequency_hz,
	output logic                              zero_period
);

	localparam int CW = COUNTER_WIDTH;
	localparam int FW = icfm_pkg::FREQ_W;
	localparam int PW = icfm_pkg::CAP_W;
	localparam int SW = icfm_pkg::STEP_W;

	logic [FW-1:0] clock_hz_q;
	logic [CW-1:0] first_q;
	logic [CW-1:0] period_q;
	logic [CW-1:0] rem_q;
	logic [FW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          out_valid_q;
	logic [PW-1:0] period_out_q;
	logic [FW-1:0] freq_out_q;
	logic          zero_out_q;

	logic [CW-1:0] cap;
	logic [CW-1:0] diff;
	logic [CW-1:0] period_d;
	logic [PW-1:0] period_trunc;
	logic [CW:0]   trial;
	logic [CW:0]   trial_sub;
	logic          trial_ge;
	logic          period_zero;

	if (CW >= PW) begin : g_wide
		assign cap          = CW'(capture_value);
		assign period_trunc = period_q[PW-1:0];
	end else begin : g_narrow
		assign cap          = capture_value[CW-1:0];
		assign period_trunc = PW'(period_q);
	end

	// wrap: (max - first) + cap == cap - first - 1 modulo 2^CW
	assign diff     = cap - first_q;
	assign period_d = (cap < first_q) ? (diff - CW'(1)) : diff;

	assign trial       = {rem_q, quo_q[FW-1]};
	assign trial_sub   = trial - {1'b0, period_q};
	assign trial_ge    = (trial >= {1'b0, period_q});
	assign period_zero = (period_q == '0);

	assign sts.div_last = (step_q == SW'(icfm_pkg::DIV_STEPS - 1));
	assign sts.out_busy = out_valid_q & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= icfm_pkg::CLOCK_HZ_RESET;
		end else if (cfg_wr_en) begin
			clock_hz_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
		end else if (cmd.load_first) begin
			first_q <= cap;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			period_q <= period_d;
			rem_q    <= '0;
			quo_q    <= clock_hz_q;
		end else if (cmd.step_div) begin
			rem_q <= trial_ge ? trial_sub[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[FW-2:0], trial_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.start_div) begin
			step_q <= '0;
		end else if (cmd.step_div) begin
			step_q <= step_q + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.set_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_result) begin
			period_out_q <= period_trunc;
			freq_out_q   <= period_zero ? '0 : quo_q;
			zero_out_q   <= period_zero;
		end
	end

	assign out_valid    = out_valid_q;
	assign period_ticks = period_out_q;
	assign frequency_hz = freq_out_q;
	assign zero_period  = zero_out_q;

endmodule

### design/icfm_chk.sv
// Port-level checker for the frequency meter, bound to the top level.
// Depends on assert_macros.svh and icfm_pkg.
`include "assert_macros.svh"

module icfm_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [icfm_pkg::CAP_W-1:0]   period_ticks,
	input logic [icfm_pkg::FREQ_W-1:0]  frequency_hz,
	input logic                         zero_period
);

	logic                                         held;
	logic                                         zero_bad;
	logic                                         drained;
	logic [icfm_pkg::CAP_W+icfm_pkg::FREQ_W:0]    out_bits;

	assign held     = out_valid && !out_ready;
	assign zero_bad = out_valid && zero_period && (frequency_hz != '0);
	// result taken while the divider is idle: nothing can refill the register
	assign drained  = out_valid && out_ready && in_ready;
	assign out_bits = {period_ticks, frequency_hz, zero_period};

	`ICFM_ASSERT(a_out_hold, clk, arst_n, held |=> out_valid, "result dropped while stalled")
	`ICFM_ASSERT(a_out_stable, clk, arst_n, held |=> $stable(out_bits), "result changed in stall")
	`ICFM_ASSERT_NEVER(a_zero_freq, clk, arst_n, zero_bad, "zero period with nonzero frequency")
	`ICFM_ASSERT(a_no_back_result, clk, arst_n, drained |=> !out_valid, "result repeated while idle")

endmodule

bind input_capture_frequency_meter_top icfm_chk u_icfm_chk (.*);

### test/tb.sv
// Self-checking bench for input_capture_frequency_meter_top: queued capture requests,
// an in-bench pairing/divide predictor and a result scoreboard under random back-pressure.
// Depends on icfm_pkg and the design files only.
`timescale 1ns / 100ps

module tb;

	localparam int CAP_W = icfm_pkg::CAP_W;
	localparam int FREQ_W = icfm_pkg::FREQ_W;
	localparam logic [FREQ_W-1:0] CLOCK_HZ_RESET = icfm_pkg::CLOCK_HZ_RESET;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [CAP_W-1:0] COUNT_MAX = {CAP_W{1'b1}};

	typedef struct packed {
		logic [CAP_W-1:0]  period;
		logic [FREQ_W-1:0] freq;
		logic              zero;
	} meter_result_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [FREQ_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CAP_W-1:0]  capture_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CAP_W-1:0]  period_ticks;
	logic [FREQ_W-1:0] frequency_hz;
	logic              zero_period;

	logic [CAP_W-1:0] pending_captures[$];
	meter_result_t    expected_results[$];

	// predictor state
	logic [FREQ_W-1:0] clock_rate_model = CLOCK_HZ_RESET;
	logic              pair_open = 1'b0;
	logic [CAP_W-1:0]  first_cap = '0;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	logic long_hold_armed = 1'b0;
	logic long_hold_done = 1'b0;
	int hold_count = 0;

	int error_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int zero_results = 0;
	int wrapped_pairs = 0;
	int clock_settings = 1;
	int stall_count = 0;

	meter_result_t predicted;
	meter_result_t observed;
	meter_result_t wanted;

	input_capture_frequency_meter_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.capture_value(capture_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.period_ticks (period_ticks),
		.frequency_hz (frequency_hz),
		.zero_period  (zero_period)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit measure_pair(input logic [CAP_W-1:0] cap, output meter_result_t r);
		logic [CAP_W-1:0] per;
		if (!pair_open) begin
			first_cap = cap;
			pair_open = 1'b1;
			return 1'b0;
		end
		if (cap > first_cap) begin
			per = cap - first_cap;
		end else if (cap < first_cap) begin
			per = (COUNT_MAX - first_cap) + cap;
			wrapped_pairs++;
		end else begin
			per = '0;
		end
		r.period = per;
		r.zero = (per == '0);
		r.freq = r.zero ? '0 : clock_rate_model / FREQ_W'(per);
		pair_open = 1'b0;
		return 1'b1;
	endfunction

	task automatic queue_capture_pair();
		logic [CAP_W-1:0] a, b;
		int kind;
		kind = $urandom_range(9);
		a = CAP_W'($urandom_range(16'hFFFF));
		case (kind)
			4: b = a;
			5: b = a + CAP_W'($urandom_range(16));
			6: begin
				a = COUNT_MAX - CAP_W'($urandom_range(64));
				b = CAP_W'($urandom_range(64));
			end
			7: begin
				a = COUNT_MAX;
				b = CAP_W'($urandom_range(3));
			end
			8: b = a - CAP_W'($urandom_range(1, 16));
			9: begin
				a = CAP_W'($urandom_range(3));
				b = COUNT_MAX - CAP_W'($urandom_range(3));
			end
			default: b = CAP_W'($urandom_range(16'hFFFF));
		endcase
		pending_captures.push_back(a);
		pending_captures.push_back(b);
	endtask

	task automatic write_clock_rate(input logic [FREQ_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clock_rate_model = value;
		clock_settings++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_captures.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			capture_value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				requests_sent++;
				if (measure_pair(capture_value, predicted))
					expected_results.push_back(predicted);
			end
			if (!in_valid || in_ready) begin
				if (pending_captures.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					capture_value <= pending_captures.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				observed = '{period_ticks, frequency_hz, zero_period};
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result period=%0d freq=%0d zero=%0d",
						$time, period_ticks, frequency_hz, zero_period);
				end else begin
					wanted = expected_results.pop_front();
					results_checked++;
					if (wanted.zero)
						zero_results++;
					if (observed.period !== wanted.period) begin
						error_count++;
						$display("%0t: period_ticks expected %0d actual %0d",
							$time, wanted.period, observed.period);
					end
					if (observed.freq !== wanted.freq) begin
						error_count++;
						$display("%0t: frequency_hz expected %0d actual %0d",
							$time, wanted.freq, observed.freq);
					end
					if (observed.zero !== wanted.zero) begin
						error_count++;
						$display("%0t: zero_period expected %0d actual %0d",
							$time, wanted.zero, observed.zero);
					end
				end
			end
			if (long_hold_armed && !long_hold_done) begin
				out_ready <= 1'b0;
				hold_count++;
				if (!in_ready)
					stall_count++;
				if (hold_count >= HOLD_CYCLES)
					long_hold_done <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [CAP_W-1:0] directed[24];
		logic [FREQ_W-1:0] phase_clock[7];
		int phase_items[7];
		int phase_sender[7];
		int phase_recv[7];
		directed = '{16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
			16'h1234, 16'h1234, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
			16'hFFFF, 16'h0001, 16'h0001, 16'h0000, 16'h8000, 16'h7FFF,
			16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF, 16'hAAAA, 16'h5555};
		phase_clock = '{32'hFFFF_FFFF, 32'd1, $urandom(), CLOCK_HZ_RESET, 32'd0,
			$urandom(), $urandom_range(1, 100000)};
		phase_items = '{201, 170, 170, 170, 60, 120, 170};
		phase_sender = '{0, 86, 0, 27, 0, 0, 27};
		phase_recv = '{0, 0, 86, 27, 0, 0, 27};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed pairs under the reset clock rate
		foreach (directed[i])
			pending_captures.push_back(directed[i]);
		wait_drained();

		for (int p = 0; p < 7; p++) begin
			write_clock_rate(phase_clock[p]);
			sender_idle_pct <= phase_sender[p];
			recv_stall_pct <= phase_recv[p];
			if (p == 5)
				long_hold_armed <= 1'b1;
			for (int n = 0; n < phase_items[p] / 2; n++)
				queue_capture_pair();
			if (phase_items[p] % 2 != 0)
				pending_captures.push_back(CAP_W'($urandom_range(16'hFFFF)));
			wait_drained();
		end

		$display("Covered %0d capture requests, %0d results (%0d zero period, %0d wrapped)",
			requests_sent, results_checked, zero_results, wrapped_pairs);
		$display("over %0d clock rates, mixed idle/stall rates, a %0d-cycle hold (%0d stalled)",
			clock_settings, HOLD_CYCLES, stall_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
